// ----- rtl/lattice_dot_screen_top_macros.svh -----
// Assertion helpers for the dot screen block.
`ifndef LATTICE_DOT_SCREEN_TOP_MACROS_SVH
`define LATTICE_DOT_SCREEN_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LDS_ASSERT_IMP(lbl, a, b) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    ((a) |-> (b))) else $error("lds check failed");
`define LDS_ASSERT_NXT(lbl, a, b) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    ((a) |=> (b))) else $error("lds check failed");
`else
`define LDS_ASSERT_IMP(lbl, a, b)
`define LDS_ASSERT_NXT(lbl, a, b)
`endif

`endif

// ----- rtl/lds_pkg.sv -----
`timescale 1ns / 1ps
package lds_pkg;

    localparam int SIZE_W   = 13;   // width/height register
    localparam int MAT_W    = 8;    // matrix entries
    localparam int FILL_W   = 16;   // fill radius Q2.14
    localparam int RAD_FRAC = 14;
    localparam int DET_W    = 17;
    localparam int DMAG_W   = 16;
    localparam int FIELD_W  = 12;   // pixel_x / pixel_y field width
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    typedef enum logic [CFG_AW-1:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_A      = 3'd2,
        REG_B      = 3'd3,
        REG_C      = 3'd4,
        REG_D      = 3'd5,
        REG_FILL   = 3'd6
    } t_cfg_reg;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd256;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd256;
    localparam logic [MAT_W-1:0]  RST_A      = 8'd8;
    localparam logic [MAT_W-1:0]  RST_B      = 8'd0;
    localparam logic [MAT_W-1:0]  RST_C      = 8'd0;
    localparam logic [MAT_W-1:0]  RST_D      = 8'd8;
    localparam logic [FILL_W-1:0] RST_FILL   = 16'd4096;

endpackage

// ----- rtl/lattice_dot_screen_top.sv -----
`timescale 1ns / 1ps
// channel   | dir | payload (low bit first)              | handshake
// s_axis    | in  | tdata: pixel_x[11:0], pixel_y[23:12] | tvalid/tready
// m_axis    | out | tdata: coverage[0]; tuser: degen[0]  | tvalid/tready
// cfg       | in  | i_cfg_addr (reg index), i_cfg_data   | i_cfg_valid/o_cfg_ready
//
// One pixel per clock while m_axis is not stalled. From input accept to output
// valid a pixel passes a seed stage, the bit-per-stage divider that
// normalizes x and y, then six math stages.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Each stage moves when it is empty or the next one moves, so bubbles close up
// under an output stall and nothing is lost or repeated.
`include "lattice_dot_screen_top_macros.svh"

module lattice_dot_screen_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,   // pixel_x, pixel_y
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // coverage, zero pad
    output logic [0:0]                  m_axis_tuser,   // degenerate
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lds_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [lds_pkg::CFG_DW-1:0]  i_cfg_data
);
    import lds_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int NS   = F + 7;
    localparam int CCW  = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
    localparam int PRW  = F + 9;        // a*X
    localparam int PW   = F + 10;       // px
    localparam int EW   = F + 2;        // corner offset
    localparam int QW   = F + 10;       // d*ex
    localparam int UW   = F + 11;       // u, v
    localparam int MW   = F + 9;        // |u| < 2^(F+8)
    localparam int SQW  = 2 * MW;
    localparam int CMPW = 2 * F + 50;
    localparam int SP1  = F + 1;
    localparam int SP2  = F + 2;
    localparam int SP3  = F + 3;
    localparam int SP4  = F + 4;
    localparam int SP5  = F + 5;
    localparam int SP6  = F + 6;

    // ---------------- configuration ----------------
    logic [SIZE_W-1:0]       r_width, r_height;
    logic signed [MAT_W-1:0] r_a, r_b, r_c, r_d;
    logic [FILL_W-1:0]       r_fill;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_a      <= RST_A;
            r_b      <= RST_B;
            r_c      <= RST_C;
            r_d      <= RST_D;
            r_fill   <= RST_FILL;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                REG_A:      r_a      <= i_cfg_data[MAT_W-1:0];
                REG_B:      r_b      <= i_cfg_data[MAT_W-1:0];
                REG_C:      r_c      <= i_cfg_data[MAT_W-1:0];
                REG_D:      r_d      <= i_cfg_data[MAT_W-1:0];
                REG_FILL:   r_fill   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // static terms, registered in steps after a write: r_det and r_rsq, then r_dmag, then r_rhs
    logic signed [DET_W-1:0] r_det;
    logic [DMAG_W-1:0]       r_dmag;
    logic [2*FILL_W-1:0]     r_rsq;
    logic [2*FILL_W+DMAG_W-1:0] r_rhs;
    logic [DET_W-1:0]        det_neg;

    assign det_neg = -r_det;

    always_ff @(posedge i_clk) begin
        r_det  <= DET_W'($signed(DET_W'(r_a)) * $signed(DET_W'(r_d)))
                - DET_W'($signed(DET_W'(r_b)) * $signed(DET_W'(r_c)));
        r_dmag <= r_det[DET_W-1] ? det_neg[DMAG_W-1:0] : r_det[DMAG_W-1:0];
        r_rsq  <= (2*FILL_W)'(r_fill) * (2*FILL_W)'(r_fill);
        r_rhs  <= (2*FILL_W+DMAG_W)'(r_rsq) * (2*FILL_W+DMAG_W)'(r_dmag);
    end

    logic [SIZE_W-1:0] w_eff, h_eff;
    assign w_eff = (r_width  == '0) ? SIZE_W'(1) : r_width;
    assign h_eff = (r_height == '0) ? SIZE_W'(1) : r_height;

    // ---------------- stage control ----------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = m_axis_tready || !r_v[NS-1];
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: saturation check, divider seed ----------------
    logic [SIZE_W-1:0] r_rx [0:F];
    logic [SIZE_W-1:0] r_ry [0:F];
    logic [F-1:0]      r_qx [0:F];
    logic [F-1:0]      r_qy [0:F];
    logic              r_sx [0:F];
    logic              r_sy [0:F];

    logic [15:0]     in_x16, in_y16;
    logic [CCW-1:0]  cx_ext, cy_ext;
    logic            sat_x, sat_y;

    assign in_x16 = 16'(s_axis_tdata[FIELD_W-1:0]);
    assign in_y16 = 16'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
    assign cx_ext = CCW'(in_x16[COORD_BITS-1:0]);
    assign cy_ext = CCW'(in_y16[COORD_BITS-1:0]);
    // x*2^F/w overflows F bits exactly when x >= w
    assign sat_x  = cx_ext >= CCW'(w_eff);
    assign sat_y  = cy_ext >= CCW'(h_eff);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rx[0] <= sat_x ? '0 : cx_ext[SIZE_W-1:0];
            r_ry[0] <= sat_y ? '0 : cy_ext[SIZE_W-1:0];
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_sx[0] <= sat_x;
            r_sy[0] <= sat_y;
        end
    end

    // ---------------- stages 1..F: restoring divide, one bit each ----------------
    for (genvar k = 1; k <= F; k++) begin : g_div
        logic [SIZE_W:0] tx, ty, dx, dy;
        logic            gx, gy;

        assign tx = {r_rx[k-1], 1'b0};
        assign ty = {r_ry[k-1], 1'b0};
        assign gx = tx >= {1'b0, w_eff};
        assign gy = ty >= {1'b0, h_eff};
        assign dx = tx - {1'b0, w_eff};
        assign dy = ty - {1'b0, h_eff};

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_rx[k] <= gx ? dx[SIZE_W-1:0] : tx[SIZE_W-1:0];
                r_ry[k] <= gy ? dy[SIZE_W-1:0] : ty[SIZE_W-1:0];
                r_qx[k] <= {r_qx[k-1][F-2:0], gx};
                r_qy[k] <= {r_qy[k-1][F-2:0], gy};
                r_sx[k] <= r_sx[k-1];
                r_sy[k] <= r_sy[k-1];
            end
        end
    end

    // ---------------- P1: map products ----------------
    logic [F-1:0] nx, ny;
    logic signed [PRW-1:0] r_ax, r_by, r_cx, r_dy;

    assign nx = r_sx[F] ? '1 : r_qx[F];
    assign ny = r_sy[F] ? '1 : r_qy[F];

    always_ff @(posedge i_clk) begin
        if (en[SP1]) begin
            r_ax <= $signed(PRW'(r_a)) * $signed(PRW'(nx));
            r_by <= $signed(PRW'(r_b)) * $signed(PRW'(ny));
            r_cx <= $signed(PRW'(r_c)) * $signed(PRW'(nx));
            r_dy <= $signed(PRW'(r_d)) * $signed(PRW'(ny));
        end
    end

    // ---------------- P2: lattice position ----------------
    logic signed [PW-1:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (en[SP2]) begin
            r_px <= PW'(r_ax) + PW'(r_by);
            r_py <= PW'(r_cx) + PW'(r_dy);
        end
    end

    // ---------------- P3: corner offsets times matrix ----------------
    // ex = lx*2^F - px for floor (0) and ceil (1) corners
    logic signed [EW-1:0] ex0, ex1, ey0, ey1;
    logic [F-1:0]         frx, fry;
    logic signed [QW-1:0] r_dex [0:1];
    logic signed [QW-1:0] r_cex [0:1];
    logic signed [QW-1:0] r_bey [0:1];
    logic signed [QW-1:0] r_aey [0:1];

    assign frx = r_px[F-1:0];
    assign fry = r_py[F-1:0];
    assign ex0 = -$signed({2'b00, frx});
    assign ey0 = -$signed({2'b00, fry});
    assign ex1 = (frx == '0) ? '0 : $signed({2'b01, {F{1'b0}}}) - $signed({2'b00, frx});
    assign ey1 = (fry == '0) ? '0 : $signed({2'b01, {F{1'b0}}}) - $signed({2'b00, fry});

    always_ff @(posedge i_clk) begin
        if (en[SP3]) begin
            r_dex[0] <= $signed(QW'(r_d)) * $signed(QW'(ex0));
            r_dex[1] <= $signed(QW'(r_d)) * $signed(QW'(ex1));
            r_cex[0] <= $signed(QW'(r_c)) * $signed(QW'(ex0));
            r_cex[1] <= $signed(QW'(r_c)) * $signed(QW'(ex1));
            r_bey[0] <= $signed(QW'(r_b)) * $signed(QW'(ey0));
            r_bey[1] <= $signed(QW'(r_b)) * $signed(QW'(ey1));
            r_aey[0] <= $signed(QW'(r_a)) * $signed(QW'(ey0));
            r_aey[1] <= $signed(QW'(r_a)) * $signed(QW'(ey1));
        end
    end

    // ---------------- P4: u, v per corner (index 2*i + j) ----------------
    logic signed [UW-1:0] r_u [0:3];
    logic signed [UW-1:0] r_w [0:3];

    always_ff @(posedge i_clk) begin
        if (en[SP4]) begin
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r_u[2*i+j] <= UW'(r_dex[i]) - UW'(r_bey[j]);
                    r_w[2*i+j] <= UW'(r_aey[j]) - UW'(r_cex[i]);
                end
            end
        end
    end

    // ---------------- P5: squares ----------------
    logic [SQW-1:0] r_uu [0:3];
    logic [SQW-1:0] r_ww [0:3];
    logic [UW-1:0]  mu [0:3];
    logic [UW-1:0]  mw [0:3];

    always_comb begin
        for (int n = 0; n < 4; n++) begin
            mu[n] = r_u[n][UW-1] ? UW'(-r_u[n]) : UW'(r_u[n]);
            mw[n] = r_w[n][UW-1] ? UW'(-r_w[n]) : UW'(r_w[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[SP5]) begin
            for (int n = 0; n < 4; n++) begin
                r_uu[n] <= SQW'(mu[n][MW-1:0]) * SQW'(mu[n][MW-1:0]);
                r_ww[n] <= SQW'(mw[n][MW-1:0]) * SQW'(mw[n][MW-1:0]);
            end
        end
    end

    // ---------------- P6: compare, output register ----------------
    logic [CMPW-1:0] rhs_cmp;
    logic [CMPW-1:0] lhs_cmp [0:3];
    logic            hit;
    logic            det_zero;
    logic            r_cov, r_deg;

    assign rhs_cmp  = CMPW'(r_rhs) << (2 * F);
    assign det_zero = r_det == '0;

    always_comb begin
        hit = 1'b0;
        for (int n = 0; n < 4; n++) begin
            lhs_cmp[n] = (CMPW'(r_uu[n]) + CMPW'(r_ww[n])) << (2 * RAD_FRAC);
            hit = hit || (lhs_cmp[n] < rhs_cmp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[SP6]) begin
            r_cov <= hit && !det_zero;
            r_deg <= det_zero;
        end
    end

    assign m_axis_tvalid   = r_v[NS-1];
    assign m_axis_tdata    = {7'd0, r_cov};
    assign m_axis_tuser[0] = r_deg;

    `LDS_ASSERT_IMP(a_degen_no_cov, m_axis_tvalid && m_axis_tuser[0], !m_axis_tdata[0])
    `LDS_ASSERT_NXT(a_out_kept, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `LDS_ASSERT_IMP(a_ready_when_empty, !r_v[NS-1], s_axis_tready)
    `LDS_ASSERT_IMP(a_zero_fill, m_axis_tvalid && r_fill == '0, !m_axis_tdata[0])

endmodule

// ----- tb/lds_checker.sv -----
`timescale 1ns / 1ps
module lds_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_px_valid,
    input  logic        i_px_ready,
    input  logic [23:0] i_px_data,
    input  logic        i_cov_valid,
    input  logic        i_cov_ready,
    input  logic [7:0]  i_cov_data,
    input  logic [0:0]  i_cov_user,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import lds_pkg::*;

    localparam int FB = 16;

    typedef struct packed {
        logic coverage;
        logic degenerate;
    } t_dot;

    t_dot dot_q[$];
    logic [12:0] width_r, height_r;
    logic signed [7:0] ma, mb, mc, md;
    logic [15:0] fill_r;

    function automatic longint norm_coord(longint coord, longint size);
        longint s, q;
        s = (size == 0) ? 1 : size;
        q = (coord << FB) / s;
        if (q > (64'd1 << FB) - 1) q = (64'd1 << FB) - 1;
        return q;
    endfunction

    function automatic longint floor_q(longint p);
        return p >>> FB;
    endfunction

    function automatic longint ceil_q(longint p);
        return -((-p) >>> FB);
    endfunction

    function automatic t_dot predict_dot(logic [11:0] px, logic [11:0] py);
        t_dot r;
        longint det, x, y, lx0, ly0, u, v;
        longint sa, sb, sc, sd;
        logic [191:0] lhs, rhs;
        sa = ma; sb = mb; sc = mc; sd = md;
        det = sa * sd - sb * sc;
        r.coverage = 1'b0;
        r.degenerate = 1'b0;
        if (det == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        x = norm_coord(px, width_r);
        y = norm_coord(py, height_r);
        rhs = 192'(fill_r) * 192'(fill_r) * 192'(det < 0 ? -det : det);
        rhs = rhs << (2 * FB);
        for (int k = 0; k < 4; k++) begin
            lx0 = k[1] ? ceil_q(sa * x + sb * y) : floor_q(sa * x + sb * y);
            ly0 = k[0] ? ceil_q(sc * x + sd * y) : floor_q(sc * x + sd * y);
            u = (sd * lx0 - sb * ly0) * (64'd1 << FB) - det * x;
            v = (sa * ly0 - sc * lx0) * (64'd1 << FB) - det * y;
            if (u < 0) u = -u;
            if (v < 0) v = -v;
            lhs = (192'(u) * 192'(u) + 192'(v) * 192'(v)) << (2 * RAD_FRAC);
            if (lhs < rhs) r.coverage = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dot want;
        if (!i_rst_n) begin
            width_r <= RST_WIDTH; height_r <= RST_HEIGHT;
            ma <= RST_A; mb <= RST_B; mc <= RST_C; md <= RST_D;
            fill_r <= RST_FILL;
            o_errors <= 0;
            o_pending <= 0;
            dot_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    REG_WIDTH:  width_r <= i_cfg_data[12:0];
                    REG_HEIGHT: height_r <= i_cfg_data[12:0];
                    REG_A:      ma <= i_cfg_data[7:0];
                    REG_B:      mb <= i_cfg_data[7:0];
                    REG_C:      mc <= i_cfg_data[7:0];
                    REG_D:      md <= i_cfg_data[7:0];
                    REG_FILL:   fill_r <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_px_valid && i_px_ready)
                dot_q.push_back(predict_dot(i_px_data[11:0], i_px_data[23:12]));
            if (i_cov_valid && i_cov_ready) begin
                if (dot_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result cov=%0d", i_cov_data[0]);
                    o_errors <= o_errors + 1;
                end else begin
                    want = dot_q.pop_front();
                    if (want.coverage !== i_cov_data[0] || want.degenerate !== i_cov_user[0]
                        || i_cov_data[7:1] !== 7'd0) begin
                        if (o_errors < 10)
                            $display("mismatch: exp cov=%0d deg=%0d got data=%h deg=%0d",
                                     want.coverage, want.degenerate, i_cov_data, i_cov_user);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= dot_q.size();
        end
    end
endmodule

// ----- tb/tb_lattice_dot_screen_top.sv -----
`timescale 1ns / 1ps
module tb_lattice_dot_screen_top;
    import lds_pkg::*;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0, s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic m_axis_tvalid, m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic i_cfg_valid = 1'b0, o_cfg_ready;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;
    int errors, pending;
    int send_idle = 0, recv_stall = 0;
    int hold_cycles = 0;
    logic hold_req = 1'b0, hold_done = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    lattice_dot_screen_top dut (.*);

    lds_checker chk (
        .i_clk, .i_rst_n,
        .i_px_valid(s_axis_tvalid), .i_px_ready(s_axis_tready), .i_px_data(s_axis_tdata),
        .i_cov_valid(m_axis_tvalid), .i_cov_ready(m_axis_tready),
        .i_cov_data(m_axis_tdata), .i_cov_user(m_axis_tuser),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_addr, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stall, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cycles <= 200;
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(t_cfg_reg idx, logic [15:0] val);
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [11:0] x, logic [11:0] y);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata <= {y, x};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_screen(int w, int h, int a, int b, int c, int d, int f);
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        write_reg(REG_A, 16'(a));
        write_reg(REG_B, 16'(b));
        write_reg(REG_C, 16'(c));
        write_reg(REG_D, 16'(d));
        write_reg(REG_FILL, 16'(f));
    endtask

    task automatic random_screen();
        int m[4];
        for (int k = 0; k < 4; k++)
            m[k] = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 64 : -64)
                                            : $signed($urandom_range(128)) - 64;
        if ($urandom_range(7) == 0) m[3] = 0;
        if ($urandom_range(7) == 0) begin m[0] = 4; m[1] = 2; m[2] = 6; m[3] = 3; end
        set_screen($urandom_range(4096), $urandom_range(4096), m[0], m[1], m[2], m[3],
                   $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(12000));
    endtask

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: reset screen, field extremes
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd255, 12'd0);
        send_pixel(12'd16, 12'd16);
        send_pixel(12'd31, 12'd33);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain();
        // zero size registers, out-of-range index, negative matrix extremes
        set_screen(0, 0, -64, 64, 64, -64, 65535);
        write_reg(t_cfg_reg'(3'd7), 16'hFFFF);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd1, 12'd0);
        drain();
        set_screen(4096, 4096, 64, -64, -64, -64, 0);
        send_pixel(12'd2048, 12'd1000);
        send_pixel(12'hFFF, 12'd0);
        drain();
        set_screen(8191, 1, 3, 6, 1, 2, 4096);   // zero determinant
        send_pixel(12'd7, 12'd9);
        send_pixel(12'd0, 12'd0);
        drain();
        set_screen(1, 8191, -1, 0, 0, 1, 16384);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd100, 12'd7);
        drain();
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 45; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 45; end
                default: begin send_idle = 24; recv_stall = 24; end
            endcase
            random_screen();
            if (ph == 5) hold_req <= 1'b1;
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(3) == 0)
                    send_pixel($urandom_range(4095), $urandom_range(4095));
                else
                    send_pixel($urandom_range(300), $urandom_range(300));
            end
            drain();
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
